[hdl/pjm_pkg.sv]
// Shared types, constants and round functions of the Pyjamask-128 cipher core.
package pjm_pkg;

   // Round counts and round-key memory geometry
   localparam int Rounds    = 14;
   localparam int KeyRounds = 14;
   localparam int RkRows    = KeyRounds + 1;
   localparam int CntW      = $clog2(RkRows);
   localparam int BlkW      = 128;
   localparam int CsrW      = 64;

   typedef logic [CntW-1:0]    cnt_type;
   typedef logic [0:3][31:0]   blk_type;   // word 0 is the most significant

   localparam cnt_type LastRound    = cnt_type'(Rounds);
   localparam cnt_type LastKeyRound = cnt_type'(KeyRounds);

   typedef enum logic [0:0] {
      OpEncrypt = 1'b0,
      OpDecrypt = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CsrKeyHigh = 1'b0,
      CsrKeyLow  = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      StIdle,
      StExpand,
      StRun
   } state_type;

   // Circulant matrix columns
   localparam logic [31:0] MatE0 = 32'ha3861085;
   localparam logic [31:0] MatE1 = 32'h63417021;
   localparam logic [31:0] MatE2 = 32'h692cf280;
   localparam logic [31:0] MatE3 = 32'h48a54813;
   localparam logic [31:0] MatK  = 32'hb881b9ca;
   localparam logic [31:0] MatD0 = 32'h2037a121;
   localparam logic [31:0] MatD1 = 32'h108ff2a0;
   localparam logic [31:0] MatD2 = 32'h9054d8c0;
   localparam logic [31:0] MatD3 = 32'h3354b117;

   // Key schedule round constants
   localparam logic [31:0] Kc0 = 32'h00000080;
   localparam logic [31:0] Kc1 = 32'h00006a00;
   localparam logic [31:0] Kc2 = 32'h003f0000;
   localparam logic [31:0] Kc3 = 32'h24000000;

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

   // GF(2) product with the circulant matrix whose first column is col
   function automatic logic [31:0] circ_mul(input logic [31:0] col, input logic [31:0] v);
      logic [31:0] acc;
      acc = '0;
      for (int k = 0; k < 32; k++) begin
         acc = acc ^ ({32{v[31-k]}} & rotr32(col, 5'(k)));
      end
      return acc;
   endfunction

   function automatic blk_type sbox(input blk_type s);
      logic [31:0] a0, a1, a2, a3;
      a0 = s[0]; a1 = s[1]; a2 = s[2]; a3 = s[3];
      a0 = a0 ^ a3;
      a3 = a3 ^ (a0 & a1);
      a0 = a0 ^ (a1 & a2);
      a1 = a1 ^ (a2 & a3);
      a2 = a2 ^ (a0 & a3);
      a2 = a2 ^ a1;
      a1 = a1 ^ a0;
      a3 = ~a3;
      return {a0, a1, a3, a2};
   endfunction

   function automatic blk_type inv_sbox(input blk_type s);
      logic [31:0] a0, a1, a2, a3;
      a0 = s[0]; a1 = s[1]; a2 = s[3]; a3 = s[2];
      a3 = ~a3;
      a1 = a1 ^ a0;
      a2 = a2 ^ a1;
      a2 = a2 ^ (a3 & a0);
      a1 = a1 ^ (a2 & a3);
      a0 = a0 ^ (a1 & a2);
      a3 = a3 ^ (a0 & a1);
      a0 = a0 ^ a3;
      return {a0, a1, a2, a3};
   endfunction

   function automatic blk_type enc_round(input blk_type s);
      blk_type t;
      t = sbox(s);
      return {circ_mul(MatE0, t[0]), circ_mul(MatE1, t[1]),
              circ_mul(MatE2, t[2]), circ_mul(MatE3, t[3])};
   endfunction

   function automatic blk_type dec_round(input blk_type s);
      blk_type t;
      t = {circ_mul(MatD0, s[0]), circ_mul(MatD1, s[1]),
           circ_mul(MatD2, s[2]), circ_mul(MatD3, s[3])};
      return inv_sbox(t);
   endfunction

   // One key schedule step: round key r to round key r+1
   function automatic blk_type key_next(input blk_type w, input cnt_type r);
      logic [31:0] t;
      blk_type     m;
      t = w[0] ^ w[1] ^ w[2] ^ w[3];
      m = {w[0] ^ t, w[1] ^ t, w[2] ^ t, w[3] ^ t};
      return {circ_mul(MatK, m[0]) ^ Kc0 ^ 32'(r),
              rotr32(m[1], 5'd8)  ^ Kc1,
              rotr32(m[2], 5'd15) ^ Kc2,
              rotr32(m[3], 5'd18) ^ Kc3};
   endfunction

endpackage

[hdl/pjm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pjm_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pyjamask_128_block_cipher.sv]
// Pyjamask-128 block cipher core: top level with key schedule and round sequencer.
//
// One block runs 14 rounds, one per cycle, and a final round-key addition,
// paced by the one read port of the round-key memory (15 rows of 128 bits).
// start is taken when busy is low; the result shows on the rsp_ ports for
// exactly one cycle with rsp_strobe high, in the cycle after the final key
// addition, and the receiver cannot stall it. busy is already low in that
// strobe cycle, so the next block can start there. A write to either key
// register starts a key expansion (one round key per cycle into the memory),
// during which busy is high; reset likewise expands the all-zero key.
// Key writes are meant for idle periods; a write restarts the expansion.
module pyjamask_128_block_cipher
   import pjm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // command channel
   input  logic            start,
   output logic            busy,
   input  logic            req_opcode,
   input  logic [63:0]     req_data_in_high,
   input  logic [63:0]     req_data_in_low,
   // result channel
   output logic            rsp_strobe,
   output logic [63:0]     rsp_data_out_high,
   output logic [63:0]     rsp_data_out_low,
   // key registers
   input  logic            csr_write_en,
   input  logic [0:0]      csr_index,
   input  logic [CsrW-1:0] csr_write_data
);

   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;
   op_type    op_ff, op_in;
   blk_type   s_ff, s_in;        // cipher state
   blk_type   w_ff, w_in;        // key schedule state
   blk_type   out_ff, out_in;
   logic      strobe_ff, strobe_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;

   // round-key memory
   logic    ram_we;
   cnt_type ram_wa, ram_ra;
   blk_type ram_wd;
   logic [BlkW-1:0] ram_rd;
   blk_type rk;
   blk_type cur_key;
   blk_type keyed;
   cnt_type nxt;

   pjm_ram #(
      .Width (BlkW),
      .Depth (RkRows)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rk      = ram_rd;
   assign keyed   = s_ff ^ rk;
   assign nxt     = cnt_ff + 1'b1;
   // row 0 of the schedule is the key itself
   assign cur_key = (cnt_ff == '0) ? blk_type'({key_high_ff, key_low_ff}) : w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StExpand;
         cnt_ff      <= '0;
         strobe_ff   <= 1'b0;
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         strobe_ff   <= strobe_in;
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
      op_ff  <= op_in;
      s_ff   <= s_in;
      w_ff   <= w_in;
      out_ff <= out_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      s_in        = s_ff;
      w_in        = w_ff;
      out_in      = out_ff;
      strobe_in   = 1'b0;
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      ram_we      = 1'b0;
      ram_wa      = cnt_ff;
      ram_wd      = cur_key;
      ram_ra      = '0;

      unique case (state_ff)
         StIdle: begin
            // fetch the first round key already in the start cycle
            ram_ra = (op_type'(req_opcode) == OpDecrypt) ? LastRound : '0;
            if (start) begin
               s_in     = {req_data_in_high, req_data_in_low};
               op_in    = op_type'(req_opcode);
               cnt_in   = '0;
               state_in = StRun;
            end
         end
         StExpand: begin
            ram_we = 1'b1;
            w_in   = key_next(cur_key, cnt_ff);
            if (cnt_ff == LastKeyRound) begin
               state_in = StIdle;
            end else begin
               cnt_in = nxt;
            end
         end
         StRun: begin
            // address of the key for the next step
            if (cnt_ff == LastRound) begin
               ram_ra = '0;
            end else if (op_ff == OpDecrypt) begin
               ram_ra = LastRound - nxt;
            end else begin
               ram_ra = nxt;
            end
            if (cnt_ff == LastRound) begin
               out_in    = keyed;
               strobe_in = 1'b1;
               state_in  = StIdle;
            end else begin
               s_in   = (op_ff == OpDecrypt) ? dec_round(keyed) : enc_round(keyed);
               cnt_in = nxt;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase

      // a key write restarts the expansion
      if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            CsrKeyHigh: key_high_in = csr_write_data;
            CsrKeyLow:  key_low_in  = csr_write_data;
         endcase
         state_in = StExpand;
         cnt_in   = '0;
      end
   end

   assign busy              = (state_ff != StIdle);
   assign rsp_strobe        = strobe_ff;
   assign rsp_data_out_high = out_ff[0:1];
   assign rsp_data_out_low  = out_ff[2:3];

endmodule

[hdl/pjm_checker.sv]
// Port-level checks of the cipher core, bound to the top level.
module pjm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_write_en
);

   // a result closes a block that was in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a block in progress");

   // an accepted command occupies the core
   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   // a block spans many cycles, so strobes never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result strobes in a row");

   // a key write starts the expansion
   a_key_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> busy)
      else $error("key write did not start expansion");

endmodule

bind pyjamask_128_block_cipher pjm_checker u_pjm_checker (.*);
